@@ rtl/kcl_pkg.sv @@
// types, codes and constants shared by the keypad code lock
package kcl_pkg;

	// sample width of the water converter and the field that carries it
	localparam int ADC_BITS   = 12;
	localparam int WATER_BITS = 12;
	localparam logic [WATER_BITS-1:0] WATER_MASK =
		(ADC_BITS >= WATER_BITS) ? {WATER_BITS{1'b1}} : WATER_BITS'((1 << ADC_BITS) - 1);

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 12;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DIGIT_FIRST     = 3'd0,
		REG_DIGIT_SECOND    = 3'd1,
		REG_DIGIT_THIRD     = 3'd2,
		REG_DIGIT_FOURTH    = 3'd3,
		REG_HOLD_TICKS      = 3'd4,
		REG_WATER_THRESHOLD = 3'd5,
		REG_ALARM_TICKS     = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CAUSE_NONE     = 2'd0,
		CAUSE_INTRUDER = 2'd1,
		CAUSE_WATER    = 2'd2
	} alarm_cause_t;

	// button numbers as they appear in the code registers
	localparam logic [2:0] KEY_ONE   = 3'd1;
	localparam logic [2:0] KEY_TWO   = 3'd2;
	localparam logic [2:0] KEY_THREE = 3'd3;
	localparam logic [2:0] KEY_FOUR  = 3'd4;

	// indicator pair, bit 0 red, bit 1 green
	localparam logic [1:0] LED_OFF   = 2'b00;
	localparam logic [1:0] LED_RED   = 2'b01;
	localparam logic [1:0] LED_GREEN = 2'b10;

	localparam logic [2:0]            RST_DIGIT_FIRST  = 3'd1;
	localparam logic [2:0]            RST_DIGIT_SECOND = 3'd3;
	localparam logic [2:0]            RST_DIGIT_THIRD  = 3'd4;
	localparam logic [2:0]            RST_DIGIT_FOURTH = 3'd2;
	localparam logic [7:0]            RST_HOLD_TICKS   = 8'd5;
	localparam logic [WATER_BITS-1:0] RST_WATER_THRESH = 12'd200;
	localparam logic [7:0]            RST_ALARM_TICKS  = 8'd10;
	localparam logic [7:0]            HOLD_MAX         = 8'd255;

	typedef struct packed {
		logic                  button_one;
		logic                  button_two;
		logic                  button_three;
		logic                  button_four;
		logic                  motion;
		logic [WATER_BITS-1:0] water_level;
	} in_item_t;

	typedef struct packed {
		logic         is_locked;
		logic         red_led;
		logic         green_led;
		logic         alarm_on;
		alarm_cause_t alarm_cause;
		logic [1:0]   code_progress;
	} out_item_t;

endpackage

@@ rtl/keypad_code_lock_with_alarm_unit.sv @@
// keypad code lock with intruder and water-leak alarm, top level
//
// Each item is one sample tick of four buttons, a motion level and a water sample; each
// item gives exactly one result item. An item is taken into an input register, then the
// lock, code and alarm logic updates the state and fills the result register. A new item is
// accepted every cycle as long as the result register drains. in_stall rises only when both
// registers hold items and out_stall is high. Configuration writes take effect at once and
// need no idle time beyond an empty pipeline; there is no clearing pass after reset.
module keypad_code_lock_with_alarm_unit
	import kcl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_item_t                out_data
);

	// configuration
	logic [3:0][2:0]        code_q;
	logic [7:0]             hold_ticks_q;
	logic [WATER_BITS-1:0]  water_thresh_q;
	logic [7:0]             alarm_ticks_q;

	// lock and alarm state
	logic [3:0]   prev_buttons_q;
	logic [1:0]   digit_pos_q;
	logic [7:0]   hold_count_q;
	logic         locked_q;
	logic [1:0]   leds_q;
	logic [7:0]   alarm_rem_q;
	alarm_cause_t alarm_reason_q;

	// pipeline
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_s2;
	logic      valid_s2;

	logic in_accept;
	logic advance;

	// next-state logic
	logic [3:0]            now;
	logic [3:0]            rise;
	logic [3:0]            fall;
	logic [7:0]            hold_d;
	logic [1:0]            digit_d;
	logic                  locked_d;
	logic [1:0]            leds_d;
	logic [2:0]            key;
	logic                  key_event;
	logic [WATER_BITS-1:0] water_m;
	alarm_cause_t          trigger;
	logic [7:0]            rem_load;
	alarm_cause_t          reason_load;
	logic                  on;
	logic [7:0]            rem_d;
	alarm_cause_t          reason_d;
	out_item_t             result_d;

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q[0]      <= RST_DIGIT_FIRST;
			code_q[1]      <= RST_DIGIT_SECOND;
			code_q[2]      <= RST_DIGIT_THIRD;
			code_q[3]      <= RST_DIGIT_FOURTH;
			hold_ticks_q   <= RST_HOLD_TICKS;
			water_thresh_q <= RST_WATER_THRESH;
			alarm_ticks_q  <= RST_ALARM_TICKS;
		end else if (cfg_wen) begin
			unique case (cfg_index) inside
				REG_DIGIT_FIRST,
				REG_DIGIT_SECOND,
				REG_DIGIT_THIRD,
				REG_DIGIT_FOURTH:    code_q[cfg_index[1:0]] <= cfg_data[2:0];
				REG_HOLD_TICKS:      hold_ticks_q   <= cfg_data[7:0];
				REG_WATER_THRESHOLD: water_thresh_q <= cfg_data[WATER_BITS-1:0];
				REG_ALARM_TICKS:     alarm_ticks_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		now  = {item_s1.button_four, item_s1.button_three, item_s1.button_two,
			item_s1.button_one};
		rise = now & ~prev_buttons_q;
		fall = prev_buttons_q & ~now;

		// hold counter follows button one regardless of which event wins
		hold_d = hold_count_q;
		if (rise[0]) begin
			hold_d = 8'd1;
		end else if (now[0] && hold_count_q != HOLD_MAX) begin
			hold_d = hold_count_q + 8'd1;
		end

		digit_d   = digit_pos_q;
		locked_d  = locked_q;
		leds_d    = leds_q;
		key       = 3'd0;
		key_event = 1'b0;
		if (rise[0]) begin
			key       = KEY_ONE;
			key_event = 1'b1;
		end else if (fall[0]) begin
			if (hold_d >= hold_ticks_q) begin
				locked_d = 1'b1;
				leds_d   = LED_RED;
			end
		end else if (rise[1]) begin
			key       = KEY_TWO;
			key_event = 1'b1;
		end else if (rise[2]) begin
			key       = KEY_THREE;
			key_event = 1'b1;
		end else if (rise[3]) begin
			key       = KEY_FOUR;
			key_event = 1'b1;
		end

		if (key_event) begin
			if (code_q[digit_pos_q] == key) begin
				if (digit_pos_q == 2'd3) begin
					digit_d  = 2'd0;
					locked_d = 1'b0;
					leds_d   = LED_GREEN;
				end else begin
					digit_d = digit_pos_q + 2'd1;
				end
			end else begin
				digit_d = 2'd0;
			end
		end

		// intruder check sees the lock state after this item's button handling
		water_m = item_s1.water_level & WATER_MASK;
		if (item_s1.motion && locked_d) begin
			trigger = CAUSE_INTRUDER;
		end else if (water_m >= water_thresh_q) begin
			trigger = CAUSE_WATER;
		end else begin
			trigger = CAUSE_NONE;
		end

		rem_load    = alarm_rem_q;
		reason_load = alarm_reason_q;
		if (alarm_rem_q == 8'd0 && trigger != CAUSE_NONE) begin
			rem_load    = alarm_ticks_q;
			reason_load = trigger;
		end

		on       = rem_load != 8'd0;
		rem_d    = on ? rem_load - 8'd1 : rem_load;
		reason_d = (rem_d == 8'd0) ? CAUSE_NONE : reason_load;

		result_d.is_locked     = locked_d;
		result_d.red_led       = leds_d[0];
		result_d.green_led     = leds_d[1];
		result_d.alarm_on      = on;
		result_d.alarm_cause   = on ? reason_load : CAUSE_NONE;
		result_d.code_progress = digit_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_buttons_q <= 4'd0;
			digit_pos_q    <= 2'd0;
			hold_count_q   <= 8'd0;
			locked_q       <= 1'b0;
			leds_q         <= LED_OFF;
			alarm_rem_q    <= 8'd0;
			alarm_reason_q <= CAUSE_NONE;
		end else if (advance) begin
			prev_buttons_q <= now;
			digit_pos_q    <= digit_d;
			hold_count_q   <= hold_d;
			locked_q       <= locked_d;
			leds_q         <= leds_d;
			alarm_rem_q    <= rem_d;
			alarm_reason_q <= reason_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			result_s2 <= result_d;
		end
	end

`ifndef SYNTH
	a_cause_needs_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_s2.alarm_on |-> result_s2.alarm_cause == CAUSE_NONE)
		else $error("alarm cause reported with alarm off");

	a_leds_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(leds_q[0] && leds_q[1]))
		else $error("red and green indicators both on");

	a_lock_matches_red: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q == leds_q[0])
		else $error("lock state and red indicator disagree");

	a_idle_alarm_no_reason: assert property (@(posedge clk) disable iff (!arst_n)
		alarm_rem_q == 8'd0 |-> alarm_reason_q == CAUSE_NONE)
		else $error("alarm reason kept while alarm idle");

	a_stalled_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(result_s2))
		else $error("stalled result lost or changed");
`endif

endmodule
